// ===== rtl/core/hsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants of the half/single float converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  localparam logic CMD_WIDEN  = 1'b0;
  localparam logic CMD_NARROW = 1'b1;

  localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;
  localparam logic [8:0] EXP_SAT      = 9'd143;
  localparam logic [8:0] EXP_NORM_MIN = 9'd112;
  localparam logic [8:0] EXP_SUB_MIN  = 9'd101;
  localparam logic [8:0] SUB_SHIFT    = 9'd125;
  localparam logic [31:0] RND_HALF    = 32'h0000_1000;
  localparam logic [23:0] SUB_OFFSET  = 24'h7F_F000;
  localparam logic [14:0] MAG_SAT     = 15'h7FFF;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_SAT
  } cls_t;

  // Stage 1 to stage 2: operand decoded for either direction.
  typedef struct packed {
    logic        cmd;
    logic        sign;
    cls_t        cls;
    logic [8:0]  exp;
    logic [22:0] man;
    logic [3:0]  lead;
  } dec_t;

endpackage

// ===== rtl/core/hsfc_decode.sv =====
// ----------------------------------------------------------------------------
// hsfc_decode
// First stage: rounds single operands and classifies both directions.
// ----------------------------------------------------------------------------
module hsfc_decode (
  input  logic              cmd,
  input  logic [31:0]       operand,
  output hsfc_pkg::dec_t    dec
);

  logic [31:0] mag;
  logic [8:0]  e;
  logic [4:0]  he;
  logic [9:0]  hf;
  logic [3:0]  top;

  always_comb begin
    mag = {1'b0, operand[30:0]} + hsfc_pkg::RND_HALF;
    e   = mag[31:23];
    he  = operand[14:10];
    hf  = operand[9:0];
    top = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hf[i]) begin
        top = 4'(i);
      end
    end
    dec      = '0;
    dec.cmd  = cmd;
    dec.lead = top;
    if (cmd == hsfc_pkg::CMD_NARROW) begin
      dec.sign = operand[31];
      dec.exp  = e;
      dec.man  = mag[22:0];
      if (e > hsfc_pkg::EXP_SAT) begin
        dec.cls = hsfc_pkg::CLS_SAT;
      end else if (e > hsfc_pkg::EXP_NORM_MIN) begin
        dec.cls = hsfc_pkg::CLS_NORM;
      end else if (e > hsfc_pkg::EXP_SUB_MIN) begin
        dec.cls = hsfc_pkg::CLS_SUB;
      end else begin
        dec.cls = hsfc_pkg::CLS_ZERO;
      end
    end else begin
      dec.sign = operand[15];
      dec.exp  = {4'd0, he};
      dec.man  = {hf, 13'd0};
      if (he != 5'd0) begin
        dec.cls = hsfc_pkg::CLS_NORM;
      end else if (hf != 10'd0) begin
        dec.cls = hsfc_pkg::CLS_SUB;
      end else begin
        dec.cls = hsfc_pkg::CLS_ZERO;
      end
    end
  end

endmodule

// ===== rtl/core/hsfc_pack.sv =====
// ----------------------------------------------------------------------------
// hsfc_pack
// Second stage: shifts and packs the decoded value into the result word.
// ----------------------------------------------------------------------------
module hsfc_pack (
  input  hsfc_pkg::dec_t dec,
  output logic [31:0]    result
);

  logic [7:0]  wexp;
  logic [22:0] wman;
  logic [23:0] sub_val;
  logic [4:0]  sh;
  logic [14:0] nmag;
  logic [8:0]  ediff;

  always_comb begin
    wexp    = dec.exp[7:0] + hsfc_pkg::EXP_BIAS_DIFF;
    wman    = (dec.man << (5'd10 - {1'b0, dec.lead})) & 23'h7F_E000;
    sub_val = hsfc_pkg::SUB_OFFSET + {1'b0, dec.man};
    ediff   = hsfc_pkg::SUB_SHIFT - dec.exp;
    sh      = ediff[4:0];
    nmag    = 15'(((sub_val >> sh) + 24'd1) >> 1);
    result  = '0;
    if (dec.cmd == hsfc_pkg::CMD_WIDEN) begin
      case (dec.cls)
        hsfc_pkg::CLS_NORM: result = {dec.sign, wexp, dec.man};
        hsfc_pkg::CLS_SUB:  result = {dec.sign, 8'(dec.lead) + 8'd103, wman};
        default:            result = {dec.sign, 31'd0};
      endcase
    end else begin
      case (dec.cls)
        hsfc_pkg::CLS_SAT:  result = {16'd0, dec.sign, hsfc_pkg::MAG_SAT};
        hsfc_pkg::CLS_NORM: result = {16'd0, dec.sign,
                                      5'(dec.exp - hsfc_pkg::EXP_NORM_MIN),
                                      dec.man[22:13]};
        hsfc_pkg::CLS_SUB:  result = {16'd0, dec.sign, nmag};
        default:            result = {16'd0, dec.sign, 15'd0};
      endcase
    end
  end

endmodule

// ===== rtl/core/half_single_float_converter.sv =====
// ----------------------------------------------------------------------------
// half_single_float_converter
// Converts half to single and single to half, one request per cycle while not stalled.
// ----------------------------------------------------------------------------
// A request passes the operand, decoded and result registers in that order.
// Throughput: one request per cycle through three register stages unless stalled.
// A stall holds each full stage whose later stages are all full; others move.
// Reset clears all stage valid bits; payload registers are not reset.
module half_single_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result
);

  logic           v0, v1, v2;
  logic           cmd0;
  logic [31:0]    op0;
  hsfc_pkg::dec_t dec1, dec_next;
  logic [31:0]    res2, res_next;
  logic           adv0, adv1, adv2;

  assign adv2     = !v2 || !out_stall;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_stall = !adv0;
  assign out_valid = v2;
  assign result    = res2;

  hsfc_decode u_decode (.cmd(cmd0), .operand(op0), .dec(dec_next));
  hsfc_pack   u_pack   (.dec(dec1), .result(res_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      cmd0 <= cmd;
      op0  <= operand;
    end
    if (adv1) dec1 <= dec_next;
    if (adv2) res2 <= res_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("result changed while stalled");
  a_narrow_hi: assert property (@(posedge clk) disable iff (rst)
    v1 && adv2 && dec1.cmd == hsfc_pkg::CMD_NARROW |=> res2[31:16] == 16'd0)
    else $error("narrow result has upper bits set");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    v1 && !v2 |=> v2)
    else $error("stage two item lost");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half/single float converter testbench
// Drives directed and random conversion requests through the valid/stall
// handshake, predicts each result from a stated value or an independent
// conversion model, and compares the results in order under varied idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASES = 4;
  localparam int RANDOM_ITEMS = 450;
  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [31:0] operand;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result;

  logic [31:0] pending_results[$];
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off;
  bit          stim_done;

  typedef struct {
    logic        c;
    logic [31:0] op;
    bit          known;
    logic [31:0] res;
  } vec_t;

  vec_t vecs[$];

  half_single_float_converter dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .operand(operand), .out_valid(out_valid),
    .out_stall(out_stall), .result(result)
  );

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  e;
    logic [9:0]  f;
    int          lead;
    logic [22:0] man;
    sgn = {h[15], 31'b0};
    e = h[14:10];
    f = h[9:0];
    if (e != 0) begin
      return sgn | ({24'b0, 8'(e + 112)} << 23) | ({22'b0, f} << 13);
    end
    if (f == 0) begin
      return sgn;
    end
    lead = 9;
    while (f[lead] == 1'b0) lead--;
    man = 23'({f, 13'b0} << (10 - lead));
    return sgn | (32'(lead + 103) << 23) | {9'b0, man & 23'h7FE000};
  endfunction

  function automatic logic [31:0] single_to_half(logic [31:0] s);
    logic [31:0] sgn;
    logic [31:0] mag;
    logic [31:0] e;
    logic [31:0] m;
    sgn = {16'b0, s[31], 15'b0};
    mag = {1'b0, s[30:0]} + 32'h1000;
    e = mag >> 23;
    m = mag & 32'h007FFFFF;
    if (e > 143) begin
      return sgn | 32'h7FFF;
    end
    if (e > 112) begin
      return sgn | (((e - 112) << 10) & 32'h7C00) | (m >> 13);
    end
    if (e > 101) begin
      return sgn | ((((32'h007FF000 + m) >> (125 - e)) + 1) >> 1);
    end
    return sgn;
  endfunction

  function automatic logic [31:0] convert(logic c, logic [31:0] op);
    return (c == hsfc_pkg::CMD_WIDEN) ? half_to_single(op[15:0]) : single_to_half(op);
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send(logic c, logic [31:0] op, bit known, logic [31:0] res);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    operand <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, (known ? res : convert(c, op))};
  endtask

  task automatic add_vec(logic c, logic [31:0] op, bit known, logic [31:0] res);
    vec_t v;
    v.c = c;
    v.op = op;
    v.known = known;
    v.res = res;
    vecs = {vecs, v};
  endtask

  function automatic logic [31:0] random_operand(logic c);
    logic [31:0] op;
    op = $urandom;
    if (c == hsfc_pkg::CMD_NARROW && $urandom_range(3) != 0) begin
      op[30:23] = 8'($urandom_range(95, 150));
    end
    return op;
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = hsfc_pkg::CMD_WIDEN;
    operand = '0;
    out_stall = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    stim_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_0000, 1, 32'h0000_0000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'hFFFF_8000, 1, 32'h8000_0000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_3C00, 1, 32'h3F80_0000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_7FFF, 1, 32'h47FF_E000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'hABCD_FFFF, 1, 32'hC7FF_E000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_0001, 1, 32'h3380_0000);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_03FF, 0, '0);
    add_vec(hsfc_pkg::CMD_WIDEN, 32'h0000_0200, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h0000_0000, 1, 32'h0000_0000);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h8000_0000, 1, 32'h0000_8000);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h3F80_0000, 1, 32'h0000_3C00);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h7F80_0000, 1, 32'h0000_7FFF);
    add_vec(hsfc_pkg::CMD_NARROW, 32'hFFC0_0000, 1, 32'h0000_FFFF);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h7FFF_FFFF, 1, 32'h0000_7FFF);
    add_vec(hsfc_pkg::CMD_NARROW, 32'hFFFF_FFFF, 1, 32'h0000_FFFF);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h47FF_F000, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h47FF_EFFF, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h387F_F000, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h3380_0000, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h3300_0000, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h32FF_FFFF, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'hB400_1234, 0, '0);
    add_vec(hsfc_pkg::CMD_NARROW, 32'h0000_0001, 1, 32'h0000_0000);
    foreach (vecs[i]) send(vecs[i].c, vecs[i].op, vecs[i].known, vecs[i].res);

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 56 : 16) : 0;
      recv_stall_pct = (p == 2) ? 56 : ((p == 3) ? 16 : 0);
      if (p == 0) begin
        hold_off = 60;
      end
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        logic c;
        c = 1'($urandom);
        send(c, random_operand(c), 0, '0);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result: unexpected 0x%08h", result);
        errors++;
      end else begin
        logic [31:0] want;
        want = pending_results.pop_front();
        if (result !== want) begin
          $error("result: expected 0x%08h, got 0x%08h", want, result);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hsfc_pkg.sv
rtl/core/hsfc_decode.sv
rtl/core/hsfc_pack.sv
rtl/core/half_single_float_converter.sv
tb/tb.sv
